FILE: design/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared constants and types of the selectable smoothing filter: register
// map, fixed field widths and the control types of the shared datapath.
// ----------------------------------------------------------------------------
package ssf_pkg;

  // parameter defaults
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed widths of the register fields
  localparam int GAIN_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int LEN_W     = 7;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  // register reset values and limits
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd8;
  localparam logic [LEN_W-1:0]  LEN_MIN    = 7'd1;

  // filter modes
  localparam logic MODE_RECURSIVE = 1'b0;
  localparam logic MODE_AVERAGE   = 1'b1;

  // shared datapath operations
  typedef enum logic [0:0] {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

FILE: design/ssf_ram.sv
// ----------------------------------------------------------------------------
// ssf_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ssf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ssf_alu.sv
// ----------------------------------------------------------------------------
// ssf_alu
// Shared iterative unit around one adder: MSB-first shift-add multiply with
// a final accumulate step, or restoring unsigned division, one bit a cycle.
// ----------------------------------------------------------------------------
module ssf_alu #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 22
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ssf_pkg::alu_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS+17:0]         mcand_i,
  input  logic        [ssf_pkg::GAIN_W-1:0]      mult_i,
  input  logic signed [SAMPLE_BITS+16:0]         addend_i,
  input  logic        [SUM_BITS-1:0]             dividend_i,
  input  logic        [ssf_pkg::LEN_W-1:0]       divisor_i,
  output ssf_pkg::alu_stat_t                     stat_o,
  output logic signed [SAMPLE_BITS+35:0]         acc_o,
  output logic        [SUM_BITS-1:0]             quot_o
);

  import ssf_pkg::*;

  localparam int DW   = SAMPLE_BITS + 18;
  localparam int YW   = SAMPLE_BITS + 17;
  localparam int AW   = SAMPLE_BITS + 36;
  localparam int OPW  = (SUM_BITS > GAIN_W) ? SUM_BITS : GAIN_W;
  localparam int LASTN = (GAIN_W > SUM_BITS - 1) ? GAIN_W : SUM_BITS - 1;
  localparam int CNTW = $clog2(LASTN + 1);
  localparam logic [CNTW-1:0] MUL_LAST = CNTW'(GAIN_W);
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(SUM_BITS - 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  alu_op_e                op_q, op_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic signed [AW-1:0]   acc_q, acc_d;
  logic [OPW-1:0]         opr_q, opr_d;
  logic signed [DW-1:0]   mcand_q;
  logic signed [YW-1:0]   addend_q;
  logic [LEN_W-1:0]       divisor_q;

  logic signed [AW-1:0]   opa, opb, sum;
  logic                   qbit;
  logic                   last;

  // operand selection for the one shared adder
  always_comb begin
    opa  = acc_q;
    opb  = '0;
    qbit = 1'b0;
    last = 1'b0;
    case (op_q)
      ALU_MUL: begin
        if (cnt_q == MUL_LAST) begin
          opa  = acc_q;
          opb  = AW'(addend_q) <<< FRAC_W;
          last = 1'b1;
        end else begin
          opa = acc_q <<< 1;
          opb = opr_q[GAIN_W-1] ? AW'(mcand_q) : '0;
        end
      end
      ALU_DIV: begin
        opa  = AW'({acc_q[LEN_W-1:0], opr_q[SUM_BITS-1]});
        opb  = -(AW'(divisor_q));
        last = (cnt_q == DIV_LAST);
      end
      default: begin
        opa = acc_q;
        opb = '0;
      end
    endcase
    sum = opa + opb;
    if (op_q == ALU_DIV) begin
      qbit = ~sum[AW-1];
    end
  end

  // sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opr_d  = opr_q;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = ctrl_i.op;
      cnt_d  = '0;
      acc_d  = '0;
      opr_d  = (ctrl_i.op == ALU_MUL) ? OPW'(mult_i) : OPW'(dividend_i);
    end else if (busy_q) begin
      cnt_d = cnt_q + CNTW'(1);
      if (op_q == ALU_DIV) begin
        acc_d = qbit ? sum : opa;
        opr_d = {opr_q[OPW-2:0], qbit};
      end else begin
        acc_d = sum;
        opr_d = opr_q << 1;
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opr_q <= opr_d;
    if (ctrl_i.start && !busy_q) begin
      mcand_q   <= mcand_i;
      addend_q  <= addend_i;
      divisor_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;
  assign quot_o      = opr_q[SUM_BITS-1:0];

`ifndef SYNTHESIS
  // a finished operation leaves the unit free
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("alu done while still busy");
  // a start is only issued to an idle unit
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.start |-> !busy_q)
    else $error("alu started while busy");
  // done follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("alu done without work");
`endif

endmodule

FILE: design/selectable_smoothing_filter_unit.sv
// A new word is accepted only once the previous word is through the sequencer;
//   a held output word stalls the input further.
// Reset: asynchronous active low; configuration and filter state registers
//   return to their defaults and the window empties, no clearing pass is needed.
// ----------------------------------------------------------------------------
// selectable_smoothing_filter_unit
// Signed sample smoother: first-order recursive lowpass or moving average
// over a programmable window, both updated on every sample.
// ----------------------------------------------------------------------------
module selectable_smoothing_filter_unit #(
  parameter int WINDOW_MAX  = ssf_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ssf_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   smoothed_out_o
);

  import ssf_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int PTR_W    = $clog2(WINDOW_MAX);
  localparam int SUM_BITS = SB + PTR_W;
  localparam int DW       = SB + 18;
  localparam int YW       = SB + 17;
  localparam int AW       = SB + 36;
  localparam int HW       = AW - FRAC_W;
  localparam int LEN_CAP  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam logic [LEN_W-1:0]  LEN_CAP_V = LEN_W'(LEN_CAP);
  localparam logic [PTR_W:0]    WMAX_X    = (PTR_W+1)'(WINDOW_MAX);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_MAX - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic                       mode_q;
  logic [GAIN_W-1:0]          gain_q;
  logic [LEN_W-1:0]           len_q;
  logic [LEN_W-1:0]           fill_q, fill_d;
  logic [PTR_W-1:0]           wp_q, wp_d;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic signed [YW-1:0]       y_q, y_d;
  logic signed [SB-1:0]       x_q;
  logic signed [SB-1:0]       res_q, res_d;
  logic                       out_valid_q;
  logic signed [SB-1:0]       out_data_q;

  logic                       in_acc;
  logic [PTR_W:0]             old_raw;
  logic [PTR_W-1:0]           old_idx;
  logic [SB-1:0]              old_rdata;
  logic                       win_full;
  logic                       ram_we;

  alu_ctrl_t                  alu_ctrl;
  alu_stat_t                  alu_stat;
  logic signed [DW-1:0]       mcand;
  logic signed [AW-1:0]       alu_acc;
  logic [SUM_BITS-1:0]        alu_quot;
  logic [SUM_BITS-1:0]        sum_mag;

  logic signed [HW-1:0]       acc_hi;
  logic                       acc_rnd;
  logic signed [YW-1:0]       y_new;
  logic signed [SB:0]         y_hi;
  logic                       y_rnd;
  logic signed [SB-1:0]       rec_res;
  logic signed [SB-1:0]       avg_res;

  logic [LEN_W-1:0]           len_wr;
  logic [GAIN_W-1:0]          gain_wr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // oldest sample of the window, wp - len modulo the store depth
  always_comb begin
    old_raw = {1'b0, wp_q} + WMAX_X - (PTR_W+1)'(len_q);
    if (old_raw >= WMAX_X) begin
      old_raw = old_raw - WMAX_X;
    end
    old_idx = old_raw[PTR_W-1:0];
  end

  assign win_full = (fill_q >= len_q);
  assign ram_we   = (state_q == S_UPD);

  // window store
  ssf_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (x_q),
    .re_i    (in_acc),
    .raddr_i (old_idx),
    .rdata_o (old_rdata)
  );

  // lowpass step: acc = y*2^16 + alpha*(x*2^16 - y)
  assign mcand   = DW'($signed({x_q, {FRAC_W{1'b0}}})) - DW'(y_q);
  assign sum_mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);

  ssf_alu #(
    .SAMPLE_BITS (SB),
    .SUM_BITS    (SUM_BITS)
  ) u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (alu_ctrl),
    .mcand_i    (mcand),
    .mult_i     (gain_q),
    .addend_i   (y_q),
    .dividend_i (sum_mag),
    .divisor_i  (len_q),
    .stat_o     (alu_stat),
    .acc_o      (alu_acc),
    .quot_o     (alu_quot)
  );

  // truncation toward zero of the lowpass state and of its output
  always_comb begin
    acc_hi  = alu_acc[AW-1:FRAC_W];
    acc_rnd = alu_acc[AW-1] && (alu_acc[FRAC_W-1:0] != '0);
    y_new   = YW'(acc_hi + HW'(acc_rnd));
    y_hi    = y_new[YW-1:FRAC_W];
    y_rnd   = y_new[YW-1] && (y_new[FRAC_W-1:0] != '0);
    rec_res = SB'(y_hi + (SB+1)'(y_rnd));
    avg_res = sum_q[SUM_BITS-1] ? SB'(-alu_quot) : SB'(alu_quot);
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    wp_d          = wp_q;
    sum_d         = sum_q;
    y_d           = y_q;
    res_d         = res_q;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_MUL;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // window bookkeeping and start of the lowpass multiply
        if (win_full) begin
          sum_d = sum_q + SUM_BITS'(x_q) - SUM_BITS'($signed(old_rdata));
        end else begin
          sum_d  = sum_q + SUM_BITS'(x_q);
          fill_d = fill_q + LEN_W'(1);
        end
        wp_d = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
        alu_ctrl.start = 1'b1;
        alu_ctrl.op    = ALU_MUL;
        state_d        = S_MUL;
      end
      S_MUL: begin
        if (alu_stat.done) begin
          y_d = y_new;
          if (mode_q == MODE_RECURSIVE) begin
            res_d   = rec_res;
            state_d = S_OUT;
          end else if (!win_full) begin
            state_d = S_IDLE;
          end else begin
            alu_ctrl.start = 1'b1;
            alu_ctrl.op    = ALU_DIV;
            state_d        = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (alu_stat.done) begin
          res_d   = avg_res;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // register write values with their limits applied
  always_comb begin
    len_wr = cfg_data_i[LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = LEN_MIN;
    end else if (len_wr > LEN_CAP_V) begin
      len_wr = LEN_CAP_V;
    end
    gain_wr = (cfg_data_i > GAIN_ONE) ? GAIN_ONE : cfg_data_i;
  end

  // configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_RECURSIVE;
      gain_q  <= GAIN_RESET;
      len_q   <= LEN_RESET;
      fill_q  <= '0;
      wp_q    <= '0;
      sum_q   <= '0;
      y_q     <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      y_q     <= y_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FILTER_MODE:   mode_q <= cfg_data_i[0];
          REG_SMOOTH_GAIN:   gain_q <= gain_wr;
          REG_WINDOW_LENGTH: begin
            len_q  <= len_wr;
            fill_q <= '0;
            sum_q  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      x_q <= sample_in_i;
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_data_q <= res_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign smoothed_out_o = out_data_q;

`ifndef SYNTHESIS
  // no new word while the shared unit works
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !alu_stat.busy)
    else $error("input ready while alu busy");
  // alu completions arrive only where the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_stat.done |-> (state_q == S_MUL || state_q == S_DIV))
    else $error("alu done in unexpected state");
  // the window never holds more samples than its length
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= len_q)
    else $error("fill count above window length");
  // window length stays within its legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0 && len_q <= LEN_CAP_V)
    else $error("window length out of range");
`endif

endmodule

FILE: test/selectable_smoothing_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// selectable_smoothing_filter_unit_tb
// Self-checking bench for the smoothing filter. A directed table covers gain
// and window extremes, the mode switch and odd register writes. A random part
// follows, run with sender and receiver idling in turn and then not at all.
// Every accepted sample is run through a bit-accurate model of both filters,
// and each output word is compared with the oldest expected word.
// ----------------------------------------------------------------------------
module selectable_smoothing_filter_unit_tb;
  import ssf_pkg::*;

  localparam int SW   = SAMPLE_BITS_DEF;
  localparam int WMAX = WINDOW_MAX_DEF;
  localparam int PW   = $clog2(WMAX);
  localparam longint Q_ONE = longint'(1) << FRAC_W;

  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1750;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_W-1:0]       data;
    logic signed [SW-1:0]   sample;
    bit                     known;
    logic signed [SW-1:0]   known_value;
  } dir_row_t;

  // dut signals
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic signed [SW-1:0]  sample_in_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic signed [SW-1:0]  smoothed_out_o;

  // filter model state, reset values
  logic                  filt_mode = MODE_RECURSIVE;
  logic [GAIN_W-1:0]     lp_gain   = GAIN_RESET;
  logic [LEN_W-1:0]      win_len   = LEN_RESET;
  logic signed [SW+16:0] lp_state  = '0;
  logic signed [SW-1:0]  win_mem [WMAX];
  logic [PW-1:0]         win_ptr   = '0;
  logic [LEN_W-1:0]      win_fill  = '0;
  logic signed [SW+PW-1:0] win_sum = '0;

  logic signed [SW-1:0]  expected_smoothed_q [$];
  int                    mismatch_count = 0;
  int                    cycle_count    = 0;
  int                    send_idle_pct  = 0;
  int                    recv_idle_pct  = 0;

  selectable_smoothing_filter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .smoothed_out_o (smoothed_out_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // compare each output word with the oldest expectation
  always @(posedge clk_i) begin : check_words
    logic signed [SW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_smoothed_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word %0d", smoothed_out_o));
      end else begin
        want = expected_smoothed_q.pop_front();
        if (smoothed_out_o !== want)
          note_mismatch($sformatf("smoothed_out got %0d expected %0d", smoothed_out_o, want));
      end
    end
  end

  // both filters advance on every sample, the mode picks the reported one
  task automatic smooth_sample(input logic signed [SW-1:0] x, output bit has_word,
                               output logic signed [SW-1:0] word);
    longint acc;
    int     oldest;
    acc = (Q_ONE - longint'(lp_gain)) * longint'(lp_state)
        + longint'(lp_gain) * (longint'(x) * Q_ONE);
    lp_state = (SW+17)'(acc / Q_ONE);

    // running sum drops the oldest word once the window is full
    if (win_fill >= win_len) begin
      oldest = (int'(win_ptr) + WMAX - int'(win_len)) % WMAX;
      win_sum = win_sum - win_mem[oldest];
    end else begin
      win_fill = win_fill + 1'b1;
    end
    win_sum = win_sum + x;
    win_mem[win_ptr] = x;
    win_ptr = win_ptr + 1'b1;

    has_word = 1'b1;
    word     = '0;
    if (filt_mode == MODE_RECURSIVE)
      word = SW'(longint'(lp_state) / Q_ONE);
    else if (win_fill < win_len)
      has_word = 1'b0;
    else
      word = SW'(longint'(win_sum) / longint'(win_len));
  endtask

  // entered and left at a falling edge
  task automatic send_sample(input logic signed [SW-1:0] x, input bit known,
                             input logic signed [SW-1:0] known_value);
    bit                   has_word;
    logic signed [SW-1:0] word;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    smooth_sample(x, has_word, word);
    if (known)
      expected_smoothed_q.push_back(known_value);
    else if (has_word)
      expected_smoothed_q.push_back(word);
    @(negedge clk_i);
  endtask

  // stop sending and wait for the results, optionally for a silent item too
  task automatic settle_block(input bit with_drain);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_smoothed_q.size() != 0) @(negedge clk_i);
    if (with_drain) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_FILTER_MODE: filt_mode = data[0];
      REG_SMOOTH_GAIN: lp_gain = (data > GAIN_ONE) ? GAIN_ONE : data[GAIN_W-1:0];
      REG_WINDOW_LENGTH: begin
        win_len = data[LEN_W-1:0];
        if (win_len == 0)
          win_len = LEN_MIN;
        else if (win_len > WMAX)
          win_len = LEN_W'(WMAX);
        win_fill = '0;
        win_sum  = '0;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic dir_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    dir_row_t r;
    r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t row_sample(input logic signed [SW-1:0] x);
    dir_row_t r;
    r = '{ROW_SAMPLE, '0, '0, x, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t row_known(input logic signed [SW-1:0] x,
                                         input logic signed [SW-1:0] v);
    dir_row_t r;
    r = '{ROW_SAMPLE, '0, '0, x, 1'b1, v};
    return r;
  endfunction

  initial begin
    dir_row_t             rows [$];
    int                   sent;
    int                   n;
    logic [LEN_W-1:0]     len_raw;
    logic [GAIN_W-1:0]    gain_val;
    logic signed [SW-1:0] x;

    // directed table: recursive mode at reset gain, unity gain, gain clamp,
    // zero gain hold, ignored index, mode switch on a full window,
    // window lengths one, zero, two, three and truncation toward zero
    rows.push_back(row_sample(SAMPLE_MAX));
    rows.push_back(row_sample(SAMPLE_MIN));
    rows.push_back(row_write(REG_SMOOTH_GAIN, CFG_W'(GAIN_ONE)));
    rows.push_back(row_known(SAMPLE_MIN, SAMPLE_MIN));
    rows.push_back(row_known(SAMPLE_MAX, SAMPLE_MAX));
    rows.push_back(row_known(16'sd0, 16'sd0));
    rows.push_back(row_known(-16'sd1, -16'sd1));
    rows.push_back(row_write(REG_SMOOTH_GAIN, 17'h1FFFF));
    rows.push_back(row_known(16'sd1, 16'sd1));
    rows.push_back(row_write(REG_SMOOTH_GAIN, 17'd0));
    rows.push_back(row_known(16'sd12345, 16'sd1));
    rows.push_back(row_write(REG_UNUSED, 17'h1ABCD));
    rows.push_back(row_known(-16'sd5, 16'sd1));
    rows.push_back(row_write(REG_SMOOTH_GAIN, 17'd1));
    rows.push_back(row_sample(SAMPLE_MIN));
    rows.push_back(row_write(REG_FILTER_MODE, CFG_W'(MODE_AVERAGE)));
    rows.push_back(row_sample(16'sd100));
    rows.push_back(row_write(REG_WINDOW_LENGTH, 17'd1));
    rows.push_back(row_known(SAMPLE_MIN, SAMPLE_MIN));
    rows.push_back(row_known(SAMPLE_MAX, SAMPLE_MAX));
    rows.push_back(row_write(REG_WINDOW_LENGTH, 17'd0));
    rows.push_back(row_known(-16'sd7, -16'sd7));
    rows.push_back(row_write(REG_WINDOW_LENGTH, 17'd2));
    rows.push_back(row_sample(16'sd3));
    rows.push_back(row_known(-16'sd6, -16'sd1));
    rows.push_back(row_write(REG_WINDOW_LENGTH, 17'h1FF83));
    rows.push_back(row_sample(SAMPLE_MAX));
    rows.push_back(row_sample(SAMPLE_MAX));
    rows.push_back(row_known(SAMPLE_MAX, SAMPLE_MAX));
    rows.push_back(row_sample(SAMPLE_MIN));
    rows.push_back(row_write(REG_WINDOW_LENGTH, 17'd64));
    rows.push_back(row_write(REG_FILTER_MODE, CFG_W'(MODE_RECURSIVE)));
    rows.push_back(row_write(REG_SMOOTH_GAIN, CFG_W'(GAIN_RESET)));
    rows.push_back(row_sample(16'sd0));

    // reset
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct = 61;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        settle_block(1'b1);
        write_register(rows[i].index, rows[i].data);
      end else begin
        send_sample(rows[i].sample, rows[i].known, rows[i].known_value);
      end
    end

    // random segments: new settings, then a burst of samples
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 30; recv_idle_pct = 61; end
        1: begin send_idle_pct = 61; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        settle_block(1'b1);
        if ($urandom_range(0, 1) == 1)
          write_register(REG_FILTER_MODE, {16'($urandom), 1'($urandom)});
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 9))
            0: gain_val = '0;
            1: gain_val = 17'd1;
            2: gain_val = 17'd65535;
            3: gain_val = GAIN_ONE;
            4: gain_val = 17'($urandom_range(65537, 131071));
            default: gain_val = 17'($urandom_range(0, 65536));
          endcase
          write_register(REG_SMOOTH_GAIN, gain_val);
        end
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 15))
            0: len_raw = '0;
            1: len_raw = 7'd64;
            2: len_raw = 7'($urandom_range(65, 127));
            3, 4: len_raw = 7'($urandom_range(9, 63));
            default: len_raw = 7'($urandom_range(1, 8));
          endcase
          write_register(REG_WINDOW_LENGTH, {10'($urandom), len_raw});
        end
        if ($urandom_range(0, 9) == 0)
          write_register(REG_UNUSED, 17'($urandom));

        if (filt_mode == MODE_AVERAGE)
          n = int'(win_len) + $urandom_range(1, 30);
        else
          n = $urandom_range(5, 40);
        repeat (n) begin
          // hold off now and then until the output side is empty
          if ($urandom_range(0, 49) == 0) settle_block(1'b0);
          case ($urandom_range(0, 9))
            0: x = SAMPLE_MIN;
            1: x = SAMPLE_MAX;
            2: x = SW'(int'($urandom_range(0, 8)) - 4);
            default: x = SW'($urandom);
          endcase
          send_sample(x, 1'b0, '0);
        end
        sent += n;
      end
    end

    settle_block(1'b1);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
design/ssf_pkg.sv
design/ssf_ram.sv
design/ssf_alu.sv
design/selectable_smoothing_filter_unit.sv
test/selectable_smoothing_filter_unit_tb.sv
